// ----- src/fpr_pkg.sv -----
// fpr_pkg.sv: shared widths, status codes and result record for the false-position root search
// no dependencies

package fpr_pkg;

	localparam int DW            = 32;
	localparam int TOL_W         = 31;
	localparam int STEP_W        = 8;
	localparam int PROD_W        = 2 * DW;
	localparam int QW            = DW + 2;
	localparam int MAX_STEPS_DEF = 200;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

	localparam logic OP_START = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	typedef enum logic [2:0] {
		ST_EVAL       = 3'd0,
		ST_ZERO       = 3'd1,
		ST_CONV       = 3'd2,
		ST_NOBRACKET  = 3'd3,
		ST_NOCONV     = 3'd4,
		ST_UNEXPECTED = 3'd5
	} status_t;

	typedef logic signed [DW-1:0] fix_t;

	typedef struct packed {
		status_t           status;
		fix_t              point;
		fix_t              bracket_a;
		fix_t              bracket_b;
		logic [STEP_W-1:0] steps;
	} result_t;

endpackage

// ----- src/false_position_root_search_top.sv -----
// false_position_root_search_top.sv: request sequencer, bracket state and result buffering
// depends on fpr_pkg, fpr_mul, fpr_div

// Bracketed false-position root finder in signed Q16.16 that drives an outside evaluator.
// A start request loads both bracket ends and answers at once with the first point to
// evaluate; every function-value request is answered with the next point or a final status.
// Requests that need no new point (start, value for the first end, end of search, value
// while idle) are answered through the result register and the output register. A
// request that needs a new false-position point runs a 32-bit bit-serial multiply
// followed by a 34-bit restoring divide, each retiring one bit per cycle, plus setup,
// hand-over, final add and output steps. One request is worked on at a time; a second
// may be accepted while a finished answer waits at the output. The tolerance register
// is written through cfg_we.

module false_position_root_search_top import fpr_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TOL_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic signed [DW-1:0] start_a,
	input  logic signed [DW-1:0] start_b,
	input  logic signed [DW-1:0] function_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic signed [DW-1:0] point,
	output logic signed [DW-1:0] bracket_a,
	output logic signed [DW-1:0] bracket_b,
	output logic [STEP_W-1:0] steps_done
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_FA   = 4'b0010,
		PH_FB   = 4'b0100,
		PH_FX   = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_PREP = 4'b0010,
		E_MUL  = 4'b0100,
		E_DIV  = 4'b1000
	} eng_t;

	phase_t            phase_q, nphase;
	eng_t              eng_q;
	fix_t              end_a_q, end_b_q, value_a_q, value_b_q, trial_q;
	logic [STEP_W-1:0] step_q;
	logic [TOL_W-1:0]  tol_q;
	logic signed [DW:0] ntol_q;
	logic [DW-1:0]     denmag_q;
	logic              neg_q;
	logic              denz_q;
	result_t           res_q, out_q;
	logic              res_valid_q, out_valid_q;

	fix_t              na, nb, nva, nvb, ntrial;
	logic [STEP_W-1:0] nstep;
	status_t           rstat;
	fix_t              rpoint;
	logic              prop;
	logic              accept;
	logic              va_nz, fv_nz, same_sign;
	logic signed [DW:0] wdiff, tol_ext;
	logic              width_ok;

	logic [DW:0]       dpos, dneg, denp, denn;
	logic [DW-1:0]     dmag, vamag, denmag;
	logic              mul_start, mul_done, div_start, div_done;
	logic [PROD_W-1:0] product;
	logic [QW-1:0]     quot;
	logic signed [QW:0] ax, qx, xs;
	fix_t              xfin;
	logic              eng_fin, move;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (eng_q != E_IDLE) || res_valid_q;
	assign va_nz     = value_a_q != '0;
	assign fv_nz     = function_value != '0;
	assign same_sign = value_a_q[DW-1] == function_value[DW-1];
	assign tol_ext   = {2'b00, tol_q};

	always_comb begin
		na       = end_a_q;
		nb       = end_b_q;
		nva      = value_a_q;
		nvb      = value_b_q;
		ntrial   = trial_q;
		nstep    = step_q;
		nphase   = phase_q;
		rstat    = ST_EVAL;
		rpoint   = trial_q;
		prop     = 1'b0;
		wdiff    = '0;
		width_ok = 1'b0;
		if (operation == OP_START) begin
			na     = start_a;
			nb     = start_b;
			nva    = '0;
			nvb    = '0;
			nstep  = '0;
			ntrial = start_a;
			nphase = PH_FA;
			rpoint = start_a;
		end else begin
			case (phase_q)
				PH_FA: begin
					nva    = function_value;
					ntrial = end_b_q;
					nphase = PH_FB;
					rpoint = end_b_q;
				end
				PH_FB: begin
					nvb = function_value;
					if (value_a_q == function_value || (va_nz && fv_nz && same_sign)) begin
						nphase = PH_IDLE;
						rstat  = ST_NOBRACKET;
						rpoint = '0;
					end else begin
						nphase = PH_FX;
						prop   = 1'b1;
					end
				end
				PH_FX: begin
					nstep = step_q + STEP_W'(1);
					if (va_nz && fv_nz && !same_sign) begin
						nb  = trial_q;
						nvb = function_value;
					end else if (va_nz && fv_nz) begin
						na  = trial_q;
						nva = function_value;
					end else begin
						nphase = PH_IDLE;
						rstat  = ST_ZERO;
					end
					wdiff    = {na[DW-1], na} - {nb[DW-1], nb};
					width_ok = (wdiff <= tol_ext) && (wdiff >= ntol_q);
					if (rstat != ST_ZERO) begin
						if (nstep >= STEP_W'(MAX_STEPS)) begin
							nphase = PH_IDLE;
							rstat  = ST_NOCONV;
						end else if (width_ok) begin
							nphase = PH_IDLE;
							rstat  = ST_CONV;
						end else begin
							prop = 1'b1;
						end
					end
				end
				default: begin
					rstat  = ST_UNEXPECTED;
					rpoint = '0;
				end
			endcase
		end
	end

	// operand magnitudes and quotient sign
	assign dpos   = {end_a_q[DW-1], end_a_q} - {end_b_q[DW-1], end_b_q};
	assign dneg   = {end_b_q[DW-1], end_b_q} - {end_a_q[DW-1], end_a_q};
	assign dmag   = dpos[DW] ? dneg[DW-1:0] : dpos[DW-1:0];
	assign vamag  = value_a_q[DW-1] ? (DW'(0) - value_a_q) : value_a_q;
	assign denp   = {value_b_q[DW-1], value_b_q} - {value_a_q[DW-1], value_a_q};
	assign denn   = {value_a_q[DW-1], value_a_q} - {value_b_q[DW-1], value_b_q};
	assign denmag = denp[DW] ? denn[DW-1:0] : denp[DW-1:0];

	assign mul_start = eng_q == E_PREP;
	assign div_start = (eng_q == E_MUL) && mul_done;
	assign eng_fin   = (eng_q == E_DIV) && div_done;

	fpr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (dmag),
		.mplier  (vamag),
		.done    (mul_done),
		.product (product)
	);

	fpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (denmag_q),
		.done   (div_done),
		.quot   (quot)
	);

	// new point with saturation to the Q16.16 range
	always_comb begin
		ax = {{(QW+1-DW){end_a_q[DW-1]}}, end_a_q};
		qx = {1'b0, quot};
		if (denz_q) begin
			xs = ax;
		end else if (neg_q) begin
			xs = ax - qx;
		end else begin
			xs = ax + qx;
		end
		if (xs[QW:DW-1] == '0 || xs[QW:DW-1] == '1) begin
			xfin = xs[DW-1:0];
		end else begin
			xfin = xs[QW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end
	end

	assign move = res_valid_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			eng_q       <= E_IDLE;
			end_a_q     <= '0;
			end_b_q     <= '0;
			value_a_q   <= '0;
			value_b_q   <= '0;
			trial_q     <= '0;
			step_q      <= '0;
			tol_q       <= TOL_RESET;
			ntol_q      <= -{2'b00, TOL_RESET};
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q  <= cfg_data;
				ntol_q <= -{2'b00, cfg_data};
			end
			if (accept) begin
				phase_q   <= nphase;
				end_a_q   <= na;
				end_b_q   <= nb;
				value_a_q <= nva;
				value_b_q <= nvb;
				trial_q   <= ntrial;
				step_q    <= nstep;
			end else if (eng_fin) begin
				trial_q <= xfin;
			end
			case (eng_q)
				E_IDLE: begin
					if (accept && prop) begin
						eng_q <= E_PREP;
					end
				end
				E_PREP: eng_q <= E_MUL;
				E_MUL: begin
					if (mul_done) begin
						eng_q <= E_DIV;
					end
				end
				E_DIV: begin
					if (div_done) begin
						eng_q <= E_IDLE;
					end
				end
				default: eng_q <= E_IDLE;
			endcase
			if ((accept && !prop) || eng_fin) begin
				res_valid_q <= 1'b1;
			end else if (move) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eng_q == E_PREP) begin
			denmag_q <= denmag;
			neg_q    <= dpos[DW] ^ value_a_q[DW-1] ^ denp[DW];
			denz_q   <= denp == '0;
		end
		if (accept && !prop) begin
			res_q <= '{status: rstat, point: rpoint, bracket_a: na, bracket_b: nb, steps: nstep};
		end else if (eng_fin) begin
			res_q <= '{status: ST_EVAL, point: xfin, bracket_a: end_a_q, bracket_b: end_b_q,
				steps: step_q};
		end
		if (move) begin
			out_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign point      = out_q.point;
	assign bracket_a  = out_q.bracket_a;
	assign bracket_b  = out_q.bracket_b;
	assign steps_done = out_q.steps;

	a_busy_in_fx: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q != E_IDLE) |-> (phase_q == PH_FX))
		else $error("point computation running outside the awaiting-value phase");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (eng_q == E_MUL))
		else $error("multiplier finished while sequencer not waiting for it");

	a_start_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_START) |=> (res_valid_q && res_q.status == ST_EVAL))
		else $error("start request not answered with an evaluate request");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(MAX_STEPS))
		else $error("iteration count beyond step limit");

endmodule

// ----- src/fpr_mul.sv -----
// fpr_mul.sv: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on fpr_pkg

module fpr_mul import fpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     mcand,
	input  logic [DW-1:0]     mplier,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]     mcand_q;
	logic [PROD_W-1:0] acc_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DW:0]       sum;

	assign sum = {1'b0, acc_q[PROD_W-1:DW]} + (acc_q[0] ? {1'b0, mcand_q} : {(DW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= {{DW{1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[DW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- src/fpr_div.sv -----
// fpr_div.sv: restoring divider, one quotient bit per cycle, quotient saturated to 2^(DW+1)
// depends on fpr_pkg

module fpr_div import fpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [DW-1:0]     den,
	output logic              done,
	output logic [QW-1:0]     quot
);

	localparam int CW = $clog2(QW + 1);
	localparam logic [QW-1:0] Q_SAT = {2'b10, {DW{1'b0}}};

	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [QW-1:0] quot_q;
	logic          sat_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          fin_q;
	logic          done_q;

	logic [DW-1:0] rem_init;
	logic [DW:0]   t;
	logic [DW:0]   diff;
	logic          ge;

	assign rem_init = {2'b00, num[PROD_W-1:QW]};
	assign t        = {rem_q, sh_q[QW-1]};
	assign diff     = t - {1'b0, den_q};
	assign ge       = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= rem_init;
			sh_q  <= num[QW-1:0];
			sat_q <= rem_init >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end
		if (fin_q) begin
			quot_q <= (sat_q || sh_q > Q_SAT) ? Q_SAT : sh_q;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
